// ===== rtl/bra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the bitmap region allocator.
// No dependencies; every other file imports this package.
package bra_pkg;

	localparam int MAP_BITS  = 256;
	localparam int WORD_BITS = 8;
	localparam int NUM_WORDS = MAP_BITS / WORD_BITS;
	localparam int WORD_SH   = $clog2(WORD_BITS);
	localparam int WIDX_W    = $clog2(NUM_WORDS);
	localparam int POS_W     = $clog2(MAP_BITS);
	localparam int CNT_W     = $clog2(MAP_BITS + 1);
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;
	localparam logic [WORD_BITS-1:0] WORD_ONES = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 3'd0,
		OP_CLR   = 3'd1,
		OP_ANY   = 3'd2,
		OP_ALL   = 3'd3,
		OP_ALLOC = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FALSE = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic win_range;
		logic win_search;
		logic win_fill;
		logic win_sum;
		logic step_range;
		logic step_search;
		logic step_sum;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_go;
		logic alloc_go;
		logic at_last;
		logic hit;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/bra_ifs.sv =====
`timescale 1ns / 1ps
// Handshake interfaces of the bitmap region allocator: request, response
// and configuration channels. Depends on bra_pkg.
interface bra_in_if import bra_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [POS_W-1:0] start_position;
	logic [CNT_W-1:0] bit_count;

	modport source (output valid, output opcode, output start_position, output bit_count,
		input ready);
	modport sink (input valid, input opcode, input start_position, input bit_count,
		output ready);
endinterface

interface bra_out_if import bra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  found_position;
	logic              map_empty;
	logic              map_full;

	modport source (output valid, output status, output found_position, output map_empty,
		output map_full, input ready);
	modport sink (input valid, input status, input found_position, input map_empty,
		input map_full, output ready);
endinterface

interface bra_cfg_if import bra_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bra_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the bitmap region allocator.
// Depends on bra_pkg for the command and status structs.
module bra_ctrl import bra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_RANGE  = 6'b000100,
		S_SEARCH = 6'b001000,
		S_SUM    = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.range_go) begin
					cmd.win_range = 1'b1;
					state_nxt     = S_RANGE;
				end else if (stat.alloc_go) begin
					cmd.win_search = 1'b1;
					state_nxt      = S_SEARCH;
				end else begin
					cmd.win_sum = 1'b1;
					state_nxt   = S_SUM;
				end
			end
			S_RANGE: begin
				cmd.step_range = 1'b1;
				if (stat.at_last) begin
					cmd.win_sum = 1'b1;
					state_nxt   = S_SUM;
				end
			end
			S_SEARCH: begin
				cmd.step_search = 1'b1;
				if (stat.hit) begin
					// The region is found; sweep it again to mark it set.
					cmd.win_fill = 1'b1;
					state_nxt    = S_RANGE;
				end else if (stat.at_last) begin
					cmd.win_sum = 1'b1;
					state_nxt   = S_SUM;
				end
			end
			S_SUM: begin
				cmd.step_sum = 1'b1;
				if (stat.at_last) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/bra_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the bitmap region allocator: the map words, the sweep window,
// the run search, the summary flags and the result register. Depends on bra_pkg.
module bra_dp import bra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [OP_W-1:0]   in_opcode,
	input  logic [POS_W-1:0]  in_start,
	input  logic [CNT_W-1:0]  in_count,
	input  logic              cfg_wr,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] out_status,
	output logic [POS_W-1:0]  out_found,
	output logic              out_empty,
	output logic              out_full
);

	logic [WORD_BITS-1:0] map_q [NUM_WORDS];
	logic [CNT_W-1:0]     bits_in_use_q;

	logic [OP_W-1:0]  op_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] size_q;

	logic [CNT_W-1:0]  lo_q, hi_q;
	logic [WIDX_W-1:0] widx_q, last_q;

	logic acc_any_q, acc_all_q, sum_any_q, sum_all_q, found_q;
	logic [CNT_W-1:0] run_q, run_start_q;

	logic              out_valid_q, empty_q, full_q;
	logic [STAT_W-1:0] status_q;
	logic [POS_W-1:0]  found_pos_q;

	logic [WORD_BITS-1:0] rd_word, mask;
	logic [CNT_W-1:0]     size_c, end_c, win_lo_c, win_hi_c, win_hi_m1;
	logic [CNT_W:0]       bound_sum;
	logic                 oob, win_load, do_set;
	logic                 srch_hit;
	logic [CNT_W-1:0]     srch_run, srch_start;
	logic [STAT_W-1:0]    status_c;

	// A zero register value counts as one bit; values above the map size clamp to the map size.
	always_comb begin
		if (bits_in_use_q == '0) begin
			size_c = CNT_W'(1);
		end else if (bits_in_use_q > CNT_W'(MAP_BITS)) begin
			size_c = CNT_W'(MAP_BITS);
		end else begin
			size_c = bits_in_use_q;
		end
	end

	assign rd_word   = map_q[widx_q];
	assign bound_sum = {1'b0, CNT_W'(pos_q)} + {1'b0, cnt_q};
	assign oob       = bound_sum > {1'b0, size_q};
	assign end_c     = bound_sum[CNT_W-1:0];
	assign do_set    = (op_q == OP_SET) || (op_q == OP_ALLOC);

	assign stat.range_go = (op_q <= OP_ALL) && !oob && (cnt_q != '0);
	assign stat.alloc_go = (op_q == OP_ALLOC) && (cnt_q != '0) && (cnt_q <= size_q);
	assign stat.at_last  = (widx_q == last_q);
	assign stat.hit      = srch_hit;
	assign stat.out_free = !out_valid_q || out_ready;

	// Bits of the current word that lie inside the window [lo, hi).
	always_comb begin
		logic [CNT_W-1:0] bidx;
		mask = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			bidx    = CNT_W'({widx_q, WORD_SH'(j)});
			mask[j] = (bidx >= lo_q) && (bidx < hi_q);
		end
	end

	// First-fit run tracking across the eight bits of the current word.
	always_comb begin
		logic [CNT_W-1:0] bidx;
		srch_run   = run_q;
		srch_start = run_start_q;
		srch_hit   = 1'b0;
		for (int j = 0; j < WORD_BITS; j++) begin
			bidx = CNT_W'({widx_q, WORD_SH'(j)});
			if (!srch_hit && (bidx < size_q)) begin
				if (rd_word[j]) begin
					srch_run   = '0;
					srch_start = CNT_W'(bidx + 1'b1);
				end else begin
					srch_run = CNT_W'(srch_run + 1'b1);
					if (srch_run == cnt_q) begin
						srch_hit = 1'b1;
					end
				end
			end
		end
	end

	// Window for the next sweep.
	assign win_load = cmd.win_range || cmd.win_search || cmd.win_fill || cmd.win_sum;
	always_comb begin
		if (cmd.win_range) begin
			win_lo_c = CNT_W'(pos_q);
			win_hi_c = end_c;
		end else if (cmd.win_fill) begin
			win_lo_c = srch_start;
			win_hi_c = CNT_W'(srch_start + cnt_q);
		end else begin
			win_lo_c = '0;
			win_hi_c = size_q;
		end
	end
	assign win_hi_m1 = CNT_W'(win_hi_c - 1'b1);

	always_comb begin
		if (op_q > OP_ALLOC) begin
			status_c = ST_RANGE;
		end else if ((op_q <= OP_ALL) && oob) begin
			status_c = ST_RANGE;
		end else if (op_q == OP_ANY) begin
			status_c = acc_any_q ? ST_OK : ST_FALSE;
		end else if (op_q == OP_ALL) begin
			status_c = acc_all_q ? ST_OK : ST_FALSE;
		end else if (op_q == OP_ALLOC) begin
			status_c = found_q ? ST_OK : ST_FALSE;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				map_q[w] <= '0;
			end
			bits_in_use_q <= CNT_W'(MAP_BITS);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				bits_in_use_q <= cfg_data;
			end
			if (cmd.step_range) begin
				if (do_set) begin
					map_q[widx_q] <= rd_word | mask;
				end else if (op_q == OP_CLR) begin
					map_q[widx_q] <= rd_word & ~mask;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_opcode;
			pos_q       <= in_start;
			cnt_q       <= in_count;
			size_q      <= size_c;
			acc_any_q   <= 1'b0;
			acc_all_q   <= 1'b1;
			found_q     <= 1'b0;
			run_q       <= '0;
			run_start_q <= '0;
		end
		if (win_load) begin
			lo_q   <= win_lo_c;
			hi_q   <= win_hi_c;
			widx_q <= win_lo_c[POS_W-1:WORD_SH];
			last_q <= win_hi_m1[POS_W-1:WORD_SH];
		end else if (cmd.step_range || cmd.step_search || cmd.step_sum) begin
			widx_q <= WIDX_W'(widx_q + 1'b1);
		end
		if (cmd.win_sum) begin
			sum_any_q <= 1'b0;
			sum_all_q <= 1'b1;
		end
		if (cmd.step_range) begin
			acc_any_q <= acc_any_q | (|(rd_word & mask));
			acc_all_q <= acc_all_q & (&(rd_word | ~mask));
		end
		if (cmd.step_sum) begin
			sum_any_q <= sum_any_q | (|(rd_word & mask));
			sum_all_q <= sum_all_q & (&(rd_word | ~mask));
		end
		if (cmd.step_search) begin
			run_q       <= srch_run;
			run_start_q <= srch_start;
			if (srch_hit) begin
				found_q <= 1'b1;
			end
		end
		if (cmd.emit) begin
			status_q    <= status_c;
			found_pos_q <= found_q ? run_start_q[POS_W-1:0] : '0;
			empty_q     <= !sum_any_q;
			full_q      <= sum_all_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_found  = found_pos_q;
	assign out_empty  = empty_q;
	assign out_full   = full_q;

`ifndef ASSERT_OFF
	a_range_word_touched: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_range |-> (mask != '0))
		else $error("range sweep visits a word outside its window");
	a_window_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_range |-> (hi_q <= size_q))
		else $error("write window passes the managed size");
	a_run_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_search |-> (run_q < cnt_q))
		else $error("search run reached the count without a hit");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");
	a_empty_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(empty_q && full_q))
		else $error("map reported both empty and full");
`endif

endmodule

// ===== rtl/bitmap_region_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the bitmap region allocator: channel wiring of controller and
// datapath. Depends on bra_pkg, bra_ifs, bra_ctrl and bra_dp.
//
// Usage. The block keeps a 256-bit allocation map, all clear after reset.
// Each request word on req carries an opcode, a start position and a bit
// count: set a range, clear a range, test whether any or all bits of a range
// are set, or allocate the lowest first-fit run of clear bits. Every request
// yields exactly one response word on rsp with a status, the start of an
// allocated region, and whether the managed part of the map is empty or full
// after the operation. The cfg channel writes bits_in_use, the number of
// managed bits; it is always ready and is to be written only while idle.
//
// Timing. One request is worked on at a time. The map is swept one byte per
// cycle. A request passes through accept and decode, a sweep of the bytes
// touched by a range operation, or for allocate a search sweep followed by a
// sweep of the bytes of the region, then a sweep of the managed bytes to
// rebuild the empty and full flags, and finally the load of the response
// register.
//
// Reset clears the map, sets bits_in_use to 256 and empties the response
// register. A response waits in its register while rsp is stalled; the block
// returns to idle but takes the next request's result only once the stalled
// word has been taken.
module bitmap_region_allocator import bra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bra_in_if.sink    req,
	bra_out_if.source rsp,
	bra_cfg_if.sink   cfg
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	// Configuration writes are taken in any cycle.
	assign cfg.ready = 1'b1;
	assign req.ready = in_ready;

	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bra_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (req.opcode),
		.in_start   (req.start_position),
		.in_count   (req.bit_count),
		.cfg_wr     (cfg.valid),
		.cfg_data   (cfg.data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_found  (rsp.found_position),
		.out_empty  (rsp.map_empty),
		.out_full   (rsp.map_full)
	);

endmodule
